### hw/rtl/itp_pkg.sv
// Shared types, character codes and helper functions for the infix-to-postfix converter.
// No dependencies; imported by itp_front, itp_back and infix_to_postfix_converter.
package itp_pkg;

    // Operator stack sizing
    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QUEUE_AW + 1;

    // ASCII characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Stack entry codes
    localparam logic [2:0] CODE_OPEN = 3'd0;
    localparam logic [2:0] CODE_ADD  = 3'd1;
    localparam logic [2:0] CODE_SUB  = 3'd2;
    localparam logic [2:0] CODE_MUL  = 3'd3;
    localparam logic [2:0] CODE_DIV  = 3'd4;

    // Item classes
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_DIGIT = 3'd1;
    localparam logic [2:0] KIND_LOW   = 3'd2;
    localparam logic [2:0] KIND_HIGH  = 3'd3;
    localparam logic [2:0] KIND_OPEN  = 3'd4;
    localparam logic [2:0] KIND_CLOSE = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] code;
        logic [7:0] ch;
        logic       eoe;
    } itp_item_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] stack_count;
    } itp_back_status_t;

    function automatic itp_item_t itp_classify(input logic [7:0] ch, input logic eoe);
        itp_item_t it;
        it.ch   = ch;
        it.eoe  = eoe;
        it.kind = KIND_NONE;
        it.code = CODE_OPEN;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            it.kind = KIND_DIGIT;
        end else begin
            case (ch)
                CH_PLUS: begin
                    it.kind = KIND_LOW;
                    it.code = CODE_ADD;
                end
                CH_MINUS: begin
                    it.kind = KIND_LOW;
                    it.code = CODE_SUB;
                end
                CH_STAR: begin
                    it.kind = KIND_HIGH;
                    it.code = CODE_MUL;
                end
                CH_SLASH: begin
                    it.kind = KIND_HIGH;
                    it.code = CODE_DIV;
                end
                CH_OPEN:  it.kind = KIND_OPEN;
                CH_CLOSE: it.kind = KIND_CLOSE;
                default:  it.kind = KIND_NONE;
            endcase
        end
        return it;
    endfunction

    function automatic logic [7:0] itp_code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_ADD: c = CH_PLUS;
            CODE_SUB: c = CH_MINUS;
            CODE_MUL: c = CH_STAR;
            CODE_DIV: c = CH_SLASH;
            default:  c = CH_OPEN;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_front and itp_back.
//
// Feed one ASCII character per input transaction (s_in_char), with
// s_end_of_expr high on the last character of an expression. The block
// returns the postfix form one character per output transaction: digits
// pass straight through, '+' '-' bind looser than '*' '/', all are
// left-associative, parentheses group, and anything else is ignored.
// m_last_of_run marks the final result caused by one input character,
// m_expr_done the final result of a whole expression; an input that
// causes no result (including an end character whose flush is empty)
// produces no output transaction at all. The operator stack holds 16
// entries; a push onto a full stack is dropped and m_overflow_seen goes
// high and stays high until reset. Unmatched '(' are discarded at the end
// of the expression; an unmatched ')' empties the stack.
// Timing: the front queues up to four classified characters while the
// back end works. The back end takes each character through a closing
// step (the digit, the push, or the removal of the matching '(') and a
// finishing step. Each popped operator adds a step before the closing
// one, and the end-of-expression flush removes the stacked entries one
// at a time and then sees the stack empty. A character picked up while
// the back end is idle first passes through the idle state; ignored
// characters that do not end an expression never reach the back end.
// The operator stack moves one entry per cycle unless a result stall
// holds it.
// Results leave through an output register, so a stalled m_ready holds
// the back end only once a second result is waiting.
module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_expr,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run,
    output logic       m_expr_done,
    output logic       m_overflow_seen
);
    import itp_pkg::*;

    logic             q_valid;
    itp_item_t        q_item;
    logic             q_pop;
    itp_back_status_t bk_status;

    // Classify and queue incoming transactions
    itp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_expr (s_end_of_expr),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // Stack engine and result output
    itp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_last_of_run   (m_last_of_run),
        .m_expr_done     (m_expr_done),
        .m_overflow_seen (m_overflow_seen),
        .status          (bk_status)
    );

    // Expression end is always the last result of its character
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_expr_done |-> m_last_of_run)
        else $error("expr_done without last_of_run");

    // Stack never goes beyond its depth
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.stack_count <= CNT_W'(STACK_DEPTH))
        else $error("operator stack count out of range");

    // An item taken from the queue puts the back end to work
    a_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> bk_status.busy)
        else $error("queue popped but back end idle");

    // Overflow flag is sticky across results
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_overflow_seen |=> !m_valid || m_overflow_seen)
        else $error("overflow flag cleared");

endmodule

### hw/rtl/itp_front.sv
// Front end: accepts input transactions, classifies each character and queues it.
// Depends on itp_pkg.
module itp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_char,
    input  logic                s_end_of_expr,
    output logic                q_valid,
    output itp_pkg::itp_item_t  q_item,
    input  logic                q_pop
);
    import itp_pkg::*;

    itp_item_t           q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   qcnt_reg, qcnt_next;
    itp_item_t           cls;
    logic                push;

    assign cls     = itp_classify(s_in_char, s_end_of_expr);
    assign s_ready = (qcnt_reg != QCNT_W'(QUEUE_DEPTH));
    // Characters with no effect are dropped here unless they end an expression
    assign push    = s_valid && s_ready && ((cls.kind != KIND_NONE) || cls.eoe);
    assign q_valid = (qcnt_reg != '0);
    assign q_item  = q_mem[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        qcnt_next = qcnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (q_pop) begin
            rptr_next = (rptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            qcnt_next = qcnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            qcnt_next = qcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            qcnt_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/itp_back.sv
// Back end: operator stack engine, one-result hold stage and output register.
// Depends on itp_pkg.
module itp_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  itp_pkg::itp_item_t         q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_char,
    output logic                       m_last_of_run,
    output logic                       m_expr_done,
    output logic                       m_overflow_seen,
    output itp_pkg::itp_back_status_t  status
);
    import itp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    itp_item_t        cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_char_reg, pend_char_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_char_reg, m_char_next;
    logic             m_last_reg, m_last_next;
    logic             m_done_reg, m_done_next;
    logic             m_ovf_reg, m_ovf_next;

    logic [2:0]          stack_mem [STACK_DEPTH];
    logic [STACK_AW-1:0] top_idx;
    logic [2:0]          top_code;
    logic                empty, full;
    logic                do_pop, do_drop, do_push, emit_dig, step_done;
    logic                emit, stall, out_free, fin_go, xfer_mid, xfer_fin;
    logic [7:0]          emit_char;

    assign top_idx  = STACK_AW'(cnt_reg - 1'b1);
    assign top_code = stack_mem[top_idx];
    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    // One stack action per cycle, unless a result stall holds it
    always_comb begin
        do_pop    = 1'b0;
        do_drop   = 1'b0;
        do_push   = 1'b0;
        emit_dig  = 1'b0;
        step_done = 1'b0;
        case (state_reg)
            ST_PROC: begin
                case (cur_reg.kind)
                    KIND_DIGIT: begin
                        emit_dig  = 1'b1;
                        step_done = 1'b1;
                    end
                    KIND_LOW: begin
                        if (!empty && top_code != CODE_OPEN) begin
                            do_pop = 1'b1;
                        end else begin
                            do_push   = 1'b1;
                            step_done = 1'b1;
                        end
                    end
                    KIND_HIGH: begin
                        if (!empty && (top_code == CODE_MUL || top_code == CODE_DIV)) begin
                            do_pop = 1'b1;
                        end else begin
                            do_push   = 1'b1;
                            step_done = 1'b1;
                        end
                    end
                    KIND_OPEN: begin
                        do_push   = 1'b1;
                        step_done = 1'b1;
                    end
                    KIND_CLOSE: begin
                        if (empty) begin
                            step_done = 1'b1;
                        end else if (top_code == CODE_OPEN) begin
                            do_drop   = 1'b1;
                            step_done = 1'b1;
                        end else begin
                            do_pop = 1'b1;
                        end
                    end
                    default: step_done = 1'b1;
                endcase
            end
            ST_FLUSH: begin
                if (empty) begin
                    step_done = 1'b1;
                end else if (top_code == CODE_OPEN) begin
                    do_drop = 1'b1;
                end else begin
                    do_pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign emit      = do_pop || emit_dig;
    assign emit_char = emit_dig ? cur_reg.ch : itp_code_char(top_code);
    // A new result pushes the held one out; wait if the output is busy
    assign stall     = emit && pend_valid_reg && !out_free;
    assign fin_go    = (state_reg == ST_FIN) && !(pend_valid_reg && !out_free);
    assign xfer_mid  = emit && !stall && pend_valid_reg;
    assign xfer_fin  = fin_go && pend_valid_reg;
    assign q_pop     = q_valid && ((state_reg == ST_IDLE) || fin_go);

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_ovf_next      = m_ovf_reg;

        if (!stall) begin
            if (do_pop || do_drop) begin
                cnt_next = cnt_reg - 1'b1;
            end
            if (do_push) begin
                if (full) begin
                    ovf_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            if (emit) begin
                pend_valid_next = 1'b1;
                pend_char_next  = emit_char;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_next   = q_item;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                if (!stall && step_done) begin
                    state_next = cur_reg.eoe ? ST_FLUSH : ST_FIN;
                end
            end
            ST_FLUSH: begin
                if (step_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    if (q_valid) begin
                        cur_next   = q_item;
                        state_next = ST_PROC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (xfer_mid) begin
            m_valid_next = 1'b1;
            m_char_next  = pend_char_reg;
            m_last_next  = 1'b0;
            m_done_next  = 1'b0;
            m_ovf_next   = ovf_reg;
        end else if (xfer_fin) begin
            pend_valid_next = 1'b0;
            m_valid_next    = 1'b1;
            m_char_next     = pend_char_reg;
            m_last_next     = 1'b1;
            m_done_next     = cur_reg.eoe;
            m_ovf_next      = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        m_done_reg    <= m_done_next;
        m_ovf_reg     <= m_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (do_push && !stall && !full) begin
            stack_mem[cnt_reg[STACK_AW-1:0]] <= cur_reg.code;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_char         = m_char_reg;
    assign m_last_of_run      = m_last_reg;
    assign m_expr_done        = m_done_reg;
    assign m_overflow_seen    = m_ovf_reg;
    assign status.busy        = (state_reg != ST_IDLE);
    assign status.stack_count = cnt_reg;

endmodule

### sim/tb.sv
// Self-checking testbench for the infix_to_postfix_converter shunting-yard block.
// Depends on itp_pkg (character and stack codes) and the RTL under hw/rtl.
// Predicts postfix output per input character and checks each result transaction in order.
module tb;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 60;

    // One expected result transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
        logic       ovf;
    } postfix_char_t;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;
    typedef enum int {MUT_REPLACE, MUT_DROP, MUT_INSERT} mut_t;

    // Tracks the operator stack the block should hold and the postfix
    // characters it still owes us.
    class PostfixTracker;
        logic [2:0]    ops [STACK_DEPTH];
        int            depth;
        bit            overflow_flag;
        postfix_char_t expected_chars [$];
        int            chars_in;
        int            active_in;
        int            exprs;
        int            results_seen;
        int            mismatches;

        function new();
            depth         = 0;
            overflow_flag = 0;
            chars_in      = 0;
            active_in     = 0;
            exprs         = 0;
            results_seen  = 0;
            mismatches    = 0;
        endfunction

        function void push_code(logic [2:0] code);
            if (depth < STACK_DEPTH) begin
                ops[depth] = code;
                depth++;
            end else begin
                overflow_flag = 1;
            end
        endfunction

        function logic [7:0] pop_char();
            logic [7:0] c;
            depth--;
            case (ops[depth])
                CODE_ADD: c = CH_PLUS;
                CODE_SUB: c = CH_MINUS;
                CODE_MUL: c = CH_STAR;
                CODE_DIV: c = CH_SLASH;
                default:  c = CH_OPEN;
            endcase
            return c;
        endfunction

        // Called on every accepted input transaction.
        function void take_char(logic [7:0] ch, logic eoe);
            logic [7:0]    run [$];
            postfix_char_t r;
            bit            matched;
            bit            active;
            active  = 1;
            matched = 0;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                run.push_back(ch);
            end else begin
                case (ch)
                    CH_PLUS, CH_MINUS: begin
                        // low precedence: pop everything down to a '('
                        while (depth > 0 && ops[depth-1] != CODE_OPEN)
                            run.push_back(pop_char());
                        push_code(ch == CH_PLUS ? CODE_ADD : CODE_SUB);
                    end
                    CH_STAR, CH_SLASH: begin
                        while (depth > 0 &&
                               (ops[depth-1] == CODE_MUL || ops[depth-1] == CODE_DIV))
                            run.push_back(pop_char());
                        push_code(ch == CH_STAR ? CODE_MUL : CODE_DIV);
                    end
                    CH_OPEN: push_code(CODE_OPEN);
                    CH_CLOSE: begin
                        // an unmatched ')' drains the whole stack
                        while (depth > 0 && !matched) begin
                            if (ops[depth-1] == CODE_OPEN) begin
                                depth--;
                                matched = 1;
                            end else begin
                                run.push_back(pop_char());
                            end
                        end
                    end
                    default: active = 0;
                endcase
            end
            if (eoe) begin
                // flush; leftover '(' vanish silently
                while (depth > 0) begin
                    if (ops[depth-1] == CODE_OPEN)
                        depth--;
                    else
                        run.push_back(pop_char());
                end
                exprs++;
            end
            foreach (run[k]) begin
                r.ch   = run[k];
                r.last = (k == run.size() - 1);
                r.done = r.last && eoe;
                r.ovf  = overflow_flag;
                expected_chars.push_back(r);
            end
            chars_in++;
            if (active)
                active_in++;
        endfunction

        // Called on every accepted result transaction.
        function void check_char(logic [7:0] ch, logic last, logic done, logic ovf);
            postfix_char_t want;
            results_seen++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result char=%h last=%b done=%b ovf=%b",
                             ch, last, done, ovf);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last || want.done !== done ||
                want.ovf !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d exp char=%h last=%b done=%b ovf=%b,",
                              " got char=%h last=%b done=%b ovf=%b"},
                             results_seen, want.ch, want.last, want.done, want.ovf,
                             ch, last, done, ovf);
            end
        endfunction
    endclass

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char     = 8'h00;
    logic       s_end_of_expr = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_of_run;
    logic       m_expr_done;
    logic       m_overflow_seen;

    PostfixTracker tracker;
    int            cycles     = 0;
    int            burst_left = 0;
    bit            steady     = 0;
    rx_mode_t      rx_mode    = RX_OPEN;
    int            rx_left    = 0;
    int            stall_left = 0;

    infix_to_postfix_converter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_expr   (s_end_of_expr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_last_of_run   (m_last_of_run),
        .m_expr_done     (m_expr_done),
        .m_overflow_seen (m_overflow_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, tracker.expected_chars.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: switches between always-ready, mostly-ready, sparse and
    // bursty stall patterns, each held for a random stretch.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 150);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                // long stalls broken by single ready cycles
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready    <= 1'b1;
                    stall_left = $urandom_range(0, 20);
                end
            end
        endcase
    end

    // Result monitor: every accepted output transaction is checked in order.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_char(m_out_char, m_last_of_run, m_expr_done, m_overflow_seen);
    end

    // Valid low for the idle stretch; payload wanders so stale data is never trusted.
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid   <= 1'b0;
            s_in_char <= 8'($urandom);
        end
    endtask

    // One input transaction. Bursts of random length are separated by gaps
    // unless the current stretch runs steady.
    task automatic send_char(input logic [7:0] ch, input logic eoe);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!steady)
                idle_for($urandom_range(0, 8));
        end
        burst_left--;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_in_char     <= ch;
        s_end_of_expr <= eoe;
        do @(posedge aclk); while (!s_ready);
        tracker.take_char(ch, eoe);
    endtask

    task automatic send_text(input string txt, input bit end_last);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], end_last && (i == txt.len() - 1));
    endtask

    task automatic send_seq(ref logic [7:0] seq [$], input bit scatter_ends);
        logic eoe;
        for (int i = 0; i < seq.size(); i++) begin
            eoe = (i == seq.size() - 1) || (scatter_ends && $urandom_range(0, 7) == 0);
            send_char(seq[i], eoe);
        end
    endtask

    // Well-formed expression, at most max_len characters, parens included.
    task automatic build_expr(ref logic [7:0] seq [$], input int max_len);
        int opens;
        bit want_operand;
        bit running;
        logic [7:0] op_chars [4];
        op_chars     = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        seq.delete();
        opens        = 0;
        want_operand = 1;
        running      = 1;
        while (running) begin
            if (want_operand) begin
                if (seq.size() + opens + 3 <= max_len && $urandom_range(0, 3) == 0) begin
                    seq.push_back(CH_OPEN);
                    opens++;
                end else begin
                    seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    want_operand = 0;
                end
            end else if (opens > 0 && $urandom_range(0, 2) == 0) begin
                seq.push_back(CH_CLOSE);
                opens--;
            end else if (seq.size() + opens + 2 <= max_len && $urandom_range(0, 5) != 0) begin
                seq.push_back(op_chars[$urandom_range(0, 3)]);
                want_operand = 1;
            end else if (opens > 0) begin
                seq.push_back(CH_CLOSE);
                opens--;
            end else begin
                running = 0;
            end
        end
    endtask

    task automatic random_sequence();
        logic [7:0] seq [$];
        string      pool;
        int         pick;
        int         pos;
        mut_t       mut;
        pool = "()+-*/0x";
        pick = $urandom_range(0, 9);
        // Sequences stay under 16 characters and always end an expression,
        // so the stack cannot fill before the deliberate overflow phase.
        if (pick <= 6) begin
            build_expr(seq, ($urandom_range(0, 4) == 0) ? 14 : $urandom_range(1, 7));
            send_seq(seq, 0);
        end else if (pick <= 8) begin
            build_expr(seq, $urandom_range(3, 14));
            pos = $urandom_range(0, seq.size() - 1);
            mut = mut_t'($urandom_range(0, 2));
            case (mut)
                MUT_REPLACE: seq[pos] = 8'($urandom_range(0, 255));
                MUT_DROP:    seq.delete(pos);
                default:     seq.insert(pos, pool[$urandom_range(0, pool.len() - 1)]);
            endcase
            send_seq(seq, 0);
        end else begin
            // noise: raw bytes mixed with syntax characters
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1))
                    seq.push_back(8'($urandom_range(0, 255)));
                else
                    seq.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            end
            send_seq(seq, 1);
        end
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: digit extremes, every operator, precedence both ways,
        // grouping, a stray ')' that drains the stack, dangling '(' at the
        // end with an empty flush, and ignored bytes at 0x00 and 0xFF.
        send_text("0+9*1", 1);
        send_text("2/3-4", 1);
        send_text("(5-6)/7", 1);
        send_text("8*)", 1);
        send_text("((a", 1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);

        // Random part, overflow flag still clear.
        while (tracker.active_in < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                steady = !steady;
            random_sequence();
        end
        steady = 0;

        // Full stack: fifteen '(' and the '-' fill it, then '(' and '*' are pushed onto it; both are
        // dropped and the sticky flag rises.
        for (int i = 0; i < STACK_DEPTH - 1; i++)
            send_char(CH_OPEN, 1'b0);
        send_text("1-2(3*)4", 1);

        // A few more expressions to see the flag stay set.
        repeat (12) random_sequence();

        idle_for(1);
        while (tracker.expected_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters (%0d meaningful) in %0d expressions, %0d results checked",
                 tracker.chars_in, tracker.active_in, tracker.exprs, tracker.results_seen);
        $display("Stack overflow reached: %0d, mismatches: %0d, results missing: %0d",
                 tracker.overflow_flag, tracker.mismatches, tracker.expected_chars.size());
        if (tracker.mismatches == 0 && tracker.expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
